@@ sv/tcal_pkg.sv @@
// Shared widths, register indexes and helpers for the trajectory collision and length block.
package tcal_pkg;

   localparam int COORD_W           = 16;
   localparam int LEN_W             = 32;
   localparam int NUM_SLOTS         = 7;
   localparam int MAX_OBSTACLES_DEF = 7;
   localparam int CNT_W             = 3;
   localparam int REG_W             = 64;
   localparam int ADDR_W            = 6;
   localparam int SQ_W              = 2 * COORD_W + 2;
   localparam int ROOT_W            = SQ_W / 2;
   localparam int REM_W             = ROOT_W + 3;
   localparam int ITER_W            = 5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic        [COORD_W-1:0] mag_type;
   typedef logic        [CNT_W-1:0]   reg_idx_type;

   localparam reg_idx_type REG_COUNT = 3'd0;
   localparam reg_idx_type REG_OBST0 = 3'd1;

   // Absolute difference of two signed coordinates; always fits the unsigned width.
   function automatic mag_type mag_diff(input coord_type a, input coord_type b);
      logic signed [COORD_W:0] d;
      logic signed [COORD_W:0] n;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      n = -d;
      return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

endpackage

@@ sv/tcal_req_if.sv @@
// Request channel: one trajectory point with its end-of-path mark.
interface tcal_req_if;
   logic                 valid;
   logic                 ready;
   tcal_pkg::coord_type  pos_x;
   tcal_pkg::coord_type  pos_y;
   tcal_pkg::coord_type  pos_z;
   logic                 end_of_path;

   modport source (output valid, pos_x, pos_y, pos_z, end_of_path, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, end_of_path, output ready);
endinterface

@@ sv/tcal_rsp_if.sv @@
// Response channel: hit flags, running path length and final mark for one point.
interface tcal_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          point_hit;
   logic                          any_hit;
   logic [tcal_pkg::LEN_W-1:0]    path_length;
   logic                          final_flag;

   modport source (output valid, point_hit, any_hit, path_length, final_flag, input ready);
   modport sink   (input valid, point_hit, any_hit, path_length, final_flag, output ready);
endinterface

@@ sv/trajectory_collision_and_length.sv @@
// A response is ready once the sphere tests and the step are done, after the square root
// too when a previous point exists; the next request is taken only after the response
// is handed to the output stage, so it waits while rsp is held off.
// The rate is set by the single shared 16x16 multiplier (four products per sphere,
// three for the step) and the 17-step digit-by-digit square root.
// Reset (synchronous, active high) clears registers, obstacles, point state and the
// output valid; the block is ready in the first cycle with reset low.
module trajectory_collision_and_length #(
   parameter int MAX_OBSTACLES = tcal_pkg::MAX_OBSTACLES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   tcal_req_if.sink                     req_ch,
   tcal_rsp_if.source                   rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tcal_pkg::ADDR_W-1:0]  paddr,
   input  logic [tcal_pkg::REG_W-1:0]   pwdata,
   output logic [tcal_pkg::REG_W-1:0]   prdata,
   output logic                         pready
);

   localparam int CW = tcal_pkg::COORD_W;
   localparam int NW = tcal_pkg::CNT_W;
   localparam logic [NW-1:0] MaxCnt = NW'(MAX_OBSTACLES);

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_OBST = 3'd1;
   localparam logic [2:0] ST_STEP = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   // ---------------------------------------------------------------------------
   // Register file: obstacle count in flops, spheres in a small memory with
   // valid bits so that an unwritten sphere reads as zero.
   // ---------------------------------------------------------------------------
   logic [NW-1:0]                 count_ff;
   logic [tcal_pkg::REG_W-1:0]    obs_mem [tcal_pkg::NUM_SLOTS];
   logic [tcal_pkg::NUM_SLOTS-1:0] obs_vld_ff;
   logic [tcal_pkg::REG_W-1:0]    prdata_ff;
   logic [tcal_pkg::REG_W-1:0]    obs_rd_ff;

   tcal_pkg::reg_idx_type csr_idx;
   tcal_pkg::reg_idx_type csr_slot;
   logic                  csr_wr;

   assign pready   = 1'b1;
   assign csr_idx  = paddr[tcal_pkg::ADDR_W-1:3];
   assign csr_slot = NW'(csr_idx - tcal_pkg::REG_OBST0);
   assign csr_wr   = psel & penable & pwrite;
   assign prdata   = prdata_ff;

   // Clamp the programmed count to the configured maximum.
   logic [NW-1:0] obs_n;
   assign obs_n = (count_ff > MaxCnt) ? MaxCnt : count_ff;

   // ---------------------------------------------------------------------------
   // Point state and sequencer registers
   // ---------------------------------------------------------------------------
   logic [2:0]                     state_ff, state_in;
   tcal_pkg::coord_type            px_ff, py_ff, pz_ff;
   logic                           last_ff;
   tcal_pkg::coord_type            prev_x_ff, prev_y_ff, prev_z_ff;
   logic                           have_prev_ff;
   logic [tcal_pkg::LEN_W-1:0]     len_ff;
   logic                           seen_ff;
   logic                           hit_ff, hit_in;
   logic [NW-1:0]                  idx_ff, idx_in;
   logic [1:0]                     term_ff, term_in;
   logic [tcal_pkg::ITER_W-1:0]    iter_ff, iter_in;
   logic [tcal_pkg::SQ_W-1:0]      acc_ff, acc_in;
   logic [tcal_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [tcal_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic                           rsp_valid_ff;
   logic                           rsp_hit_ff, rsp_any_ff, rsp_final_ff;
   logic [tcal_pkg::LEN_W-1:0]     rsp_len_ff;

   logic req_acc;
   logic out_free;
   logic done_fire;

   // Hold off requests while reset is high so that none is taken and dropped.
   assign req_ch.ready = (state_ff == ST_IDLE) & ~reset;
   assign req_acc      = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;
   assign done_fire    = (state_ff == ST_DONE) & out_free;

   // Address of the sphere to present next: slot 0 at accept, next slot after each test.
   logic [NW-1:0] obs_rd_addr;
   assign obs_rd_addr = req_acc ? '0 : NW'(idx_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         obs_vld_ff <= '0;
      end else if (csr_wr) begin
         if (csr_idx == tcal_pkg::REG_COUNT) begin
            count_ff <= pwdata[NW-1:0];
         end else begin
            obs_vld_ff[csr_slot] <= 1'b1;
         end
      end
   end

   // Sphere memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (csr_wr && csr_idx != tcal_pkg::REG_COUNT) begin
         obs_mem[csr_slot] <= pwdata;
      end
      if (csr_idx == tcal_pkg::REG_COUNT) begin
         prdata_ff <= {{(tcal_pkg::REG_W-NW){1'b0}}, count_ff};
      end else begin
         prdata_ff <= obs_vld_ff[csr_slot] ? obs_mem[csr_slot] : '0;
      end
      // Fetch the next sphere only while one is left to test.
      if (req_acc || (state_ff == ST_OBST && term_ff == 2'd3 &&
                      NW'(idx_ff + 1'b1) != obs_n)) begin
         obs_rd_ff <= obs_vld_ff[obs_rd_addr] ? obs_mem[obs_rd_addr] : '0;
      end
   end

   // ---------------------------------------------------------------------------
   // Shared multiplier: squares one coordinate difference or the radius a cycle.
   // ---------------------------------------------------------------------------
   tcal_pkg::coord_type       op_a, op_b;
   tcal_pkg::mag_type         mul_op;
   logic [2*CW-1:0]           prod;

   always_comb begin
      op_a = px_ff;
      op_b = prev_x_ff;
      case (term_ff)
         2'd1: begin
            op_a = py_ff;
            op_b = (state_ff == ST_OBST) ? obs_rd_ff[2*CW-1:CW] : prev_y_ff;
         end
         2'd2: begin
            op_a = pz_ff;
            op_b = (state_ff == ST_OBST) ? obs_rd_ff[3*CW-1:2*CW] : prev_z_ff;
         end
         default: begin
            op_a = px_ff;
            op_b = (state_ff == ST_OBST) ? obs_rd_ff[CW-1:0] : prev_x_ff;
         end
      endcase
      // Last term of a sphere test squares the radius instead.
      if (state_ff == ST_OBST && term_ff == 2'd3) begin
         mul_op = obs_rd_ff[4*CW-1:3*CW];
      end else begin
         mul_op = tcal_pkg::mag_diff(op_a, op_b);
      end
      prod = mul_op * mul_op;
   end

   // Square root step: bring down two bits, try to subtract the trial divisor.
   logic [tcal_pkg::REM_W-1:0] rem_sh;
   logic [tcal_pkg::REM_W-1:0] trial;
   assign rem_sh = {rem_ff[tcal_pkg::REM_W-3:0], acc_ff[tcal_pkg::SQ_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   // Length update with saturation.
   logic [tcal_pkg::LEN_W:0]   len_sum;
   logic [tcal_pkg::LEN_W-1:0] len_sat;
   assign len_sum = {1'b0, len_ff} + (tcal_pkg::LEN_W+1)'(have_prev_ff ? root_ff : '0);
   assign len_sat = len_sum[tcal_pkg::LEN_W] ? '1 : len_sum[tcal_pkg::LEN_W-1:0];

   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      idx_in   = idx_ff;
      term_in  = term_ff;
      iter_in  = iter_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               hit_in   = 1'b0;
               idx_in   = '0;
               term_in  = 2'd0;
               state_in = (obs_n == '0) ? ST_STEP : ST_OBST;
            end
         end
         ST_OBST: begin
            // Accumulate dx^2, dy^2, dz^2, then compare against r^2.
            term_in = 2'(term_ff + 1'b1);
            if (term_ff == 2'd0) begin
               acc_in = tcal_pkg::SQ_W'(prod);
            end else if (term_ff == 2'd3) begin
               hit_in = hit_ff | (acc_ff <= tcal_pkg::SQ_W'(prod));
               idx_in = NW'(idx_ff + 1'b1);
               if (NW'(idx_ff + 1'b1) == obs_n) begin
                  state_in = ST_STEP;
               end
            end else begin
               acc_in = acc_ff + tcal_pkg::SQ_W'(prod);
            end
         end
         ST_STEP: begin
            // Squared step to the previous point; skip the root on a first point.
            term_in = 2'(term_ff + 1'b1);
            acc_in  = (term_ff == 2'd0) ? tcal_pkg::SQ_W'(prod)
                                        : acc_ff + tcal_pkg::SQ_W'(prod);
            if (term_ff == 2'd2) begin
               term_in  = 2'd0;
               rem_in   = '0;
               root_in  = '0;
               iter_in  = '0;
               state_in = have_prev_ff ? ST_ROOT : ST_DONE;
            end
         end
         ST_ROOT: begin
            acc_in  = {acc_ff[tcal_pkg::SQ_W-3:0], 2'b00};
            iter_in = tcal_pkg::ITER_W'(iter_ff + 1'b1);
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[tcal_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[tcal_pkg::ROOT_W-2:0], 1'b0};
            end
            if (iter_ff == tcal_pkg::ITER_W'(tcal_pkg::ROOT_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output stage can take the response.
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         len_ff       <= '0;
         seen_ff      <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         hit_ff       <= 1'b0;
         idx_ff       <= '0;
         term_ff      <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
         idx_ff   <= idx_in;
         term_ff  <= term_in;
         iter_ff  <= iter_in;
         if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
            // Drop the trajectory state after its final point, else advance it.
            if (last_ff) begin
               have_prev_ff <= 1'b0;
               len_ff       <= '0;
               seen_ff      <= 1'b0;
               prev_x_ff    <= '0;
               prev_y_ff    <= '0;
               prev_z_ff    <= '0;
            end else begin
               have_prev_ff <= 1'b1;
               len_ff       <= len_sat;
               seen_ff      <= seen_ff | hit_ff;
               prev_x_ff    <= px_ff;
               prev_y_ff    <= py_ff;
               prev_z_ff    <= pz_ff;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (req_acc) begin
         px_ff   <= req_ch.pos_x;
         py_ff   <= req_ch.pos_y;
         pz_ff   <= req_ch.pos_z;
         last_ff <= req_ch.end_of_path;
      end
      if (done_fire) begin
         rsp_hit_ff   <= hit_ff;
         rsp_any_ff   <= seen_ff | hit_ff;
         rsp_len_ff   <= len_sat;
         rsp_final_ff <= last_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.point_hit   = rsp_hit_ff;
   assign rsp_ch.any_hit     = rsp_any_ff;
   assign rsp_ch.path_length = rsp_len_ff;
   assign rsp_ch.final_flag  = rsp_final_ff;

`ifndef NO_ASSERTIONS
   // A request is never taken twice in a row: the sequencer must leave idle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ch.ready)
      else $error("request accepted while sequencer busy");

   // The root is only computed for a step with a previous point.
   a_root_needs_prev: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> have_prev_ff)
      else $error("square root started without a previous point");

   // A hit on this point must show in the sticky flag.
   a_hit_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.point_hit) |-> rsp_ch.any_hit)
      else $error("point hit without any_hit");

   // After a final point the trajectory state is clear.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (done_fire && last_ff) |=> (len_ff == '0 && !seen_ff && !have_prev_ff))
      else $error("trajectory state not cleared after final point");
`endif

endmodule
